@@ src/bayer_nearest_demosaic_assert.svh @@
// Assertion macros for the demosaic block.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef BAYER_NEAREST_DEMOSAIC_ASSERT_SVH
`define BAYER_NEAREST_DEMOSAIC_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BND_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bnd_pkg.sv @@
package bnd_pkg;

  // Default line store depth in pixels
  localparam int MAX_WIDTH_DEF = 4096;

  // Frame size limits and reset values
  localparam logic [12:0] SIZE_CAP  = 13'd4096;
  localparam logic [12:0] WIDTH_RST = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  // Bayer orders
  localparam logic [1:0] ORDER_GBRG = 2'd0;
  localparam logic [1:0] ORDER_BGGR = 2'd1;
  localparam logic [1:0] ORDER_GRBG = 2'd2;
  localparam logic [1:0] ORDER_RGGB = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BAYER_ORDER  = 2'd2;

  // Byte lane of a column word: row number modulo three
  typedef logic [1:0] lane_t;
  localparam lane_t LANE0 = 2'd0;
  localparam lane_t LANE1 = 2'd1;
  localparam lane_t LANE2 = 2'd2;

  // Selection controls of one quad
  typedef struct packed {
    lane_t       lt;     // lane of quad row i
    lane_t       lm;     // lane of quad row i+1
    lane_t       lb;     // lane of row i+2
    logic        rin;    // row i+2 lies inside the frame
    logic        cin;    // column j+2 lies inside the frame
    logic [1:0]  order;
    logic [11:0] row;
    logic [11:0] col;
  } sel_t;

  // Four finished pixels of one quad, row-major
  typedef struct packed {
    logic [3:0][7:0] blue;
    logic [3:0][7:0] green;
    logic [3:0][7:0] red;
    logic [11:0]     row;
    logic [11:0]     col;
  } quad_t;

  // Occupancy of the result buffer
  typedef struct packed {
    logic busy;
    logic pend;
  } qstat_t;

endpackage

@@ src/bayer_nearest_demosaic.sv @@
// Nearest-neighbour Bayer demosaic.
// Input channel in_*: one 8-bit raw sample per item, raster order, with
// frame_width x frame_height set through the cfg_* write port (even sizes).
// Output channel out_*: RGB pixels with their row and column; each 2x2 quad
// leaves as four items in row-major order, out_last_of_quad on the fourth.
// A quad is emitted on the item that brings its last needed neighbour.
// An accepted item is registered in the second stage, which builds its quad
// for the result buffer; its pixels leave one a cycle while out_ready is high.
// Throughput: one item a cycle on rows that emit nothing, while in_ready
// is high; on emitting rows one quad per two items, so the single output
// port, carrying four pixels per quad, sets the pace. The line store is one
// 24-bit word per column, read at two columns and written back once per item.
// Reset: counters go to the frame origin and the registers to 640 x 480,
// RGGB. The line store is not cleared; every entry is written before use.
// Receiver stall: up to two quads are held, after which in_ready drops.
module bayer_nearest_demosaic #(
  parameter int MAX_WIDTH = bnd_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_raw_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [11:0] out_pixel_row,
  output logic [11:0] out_pixel_col,
  output logic        out_last_of_quad,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int W_CAP_I = (((MAX_WIDTH / 2) * 2) > 4096) ? 4096 : ((MAX_WIDTH / 2) * 2);
  localparam logic [12:0] W_CAP = 13'(W_CAP_I);
  localparam logic [12:0] W_RST = (W_CAP < bnd_pkg::WIDTH_RST) ? W_CAP : bnd_pkg::WIDTH_RST;

  // Configuration, held as effective sizes
  logic [12:0] w_r, h_r;
  logic [1:0]  order_r;

  // Raster position of the next item
  logic [11:0]    row_r, col_r, row_nxt, col_nxt;
  bnd_pkg::lane_t lane_r, lane_nxt;

  // Position of the item at the input
  logic           col_wrap_pre, row_wrap_pre;
  logic [12:0]    row_pre;
  logic [11:0]    row_a, col_a;
  bnd_pkg::lane_t lane_a;
  logic           col_last, row_last, even_row, odd_last, inner_j1, col_step, trig;
  logic [11:0]    quad_i, quad_j;
  bnd_pkg::sel_t  sel;
  logic [AW-1:0]  rd_addr, look_addr;
  logic           in_fire;

  // Line store
  logic [23:0]    mem [MAX_WIDTH];
  logic [23:0]    rd_cur_r, rd_look_r;

  // Second stage
  logic           s1_valid_r, s1_trig_r;
  logic [7:0]     s1_pix_r;
  bnd_pkg::lane_t s1_lane_r;
  logic [AW-1:0]  s1_addr_r;
  logic           s1_odd_r;
  bnd_pkg::sel_t  s1_sel_r;
  logic [23:0]    merged;
  logic [23:0]    win1_r, win2_r;
  logic [23:0]    c0, c1, c2;
  bnd_pkg::quad_t quad;
  logic           push;

  bnd_pkg::qstat_t qstat;
  logic [1:0]      occupancy;

  function automatic logic [12:0] clamp_even(input logic [12:0] v, input logic [12:0] cap);
    logic [12:0] m;
    m = v & 13'h1FFE;
    if (m > cap) begin
      m = cap;
    end else if (m < 13'd2) begin
      m = 13'd2;
    end
    return m;
  endfunction

  function automatic bnd_pkg::lane_t inc3(input bnd_pkg::lane_t l);
    bnd_pkg::lane_t v;
    case (l)
      bnd_pkg::LANE0: v = bnd_pkg::LANE1;
      bnd_pkg::LANE1: v = bnd_pkg::LANE2;
      default:        v = bnd_pkg::LANE0;
    endcase
    return v;
  endfunction

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= W_RST;
      h_r     <= bnd_pkg::HEIGHT_RST;
      order_r <= bnd_pkg::ORDER_RGGB;
    end else if (cfg_we) begin
      case (cfg_index)
        bnd_pkg::CFG_FRAME_WIDTH:  w_r     <= clamp_even(cfg_data, W_CAP);
        bnd_pkg::CFG_FRAME_HEIGHT: h_r     <= clamp_even(cfg_data, bnd_pkg::SIZE_CAP);
        bnd_pkg::CFG_BAYER_ORDER:  order_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Normalise the position, find the trigger and the quad it completes
  always_comb begin
    col_wrap_pre = ({1'b0, col_r} >= w_r);
    row_pre      = col_wrap_pre ? ({1'b0, row_r} + 13'd1) : {1'b0, row_r};
    row_wrap_pre = (row_pre >= h_r);
    col_a        = col_wrap_pre ? '0 : col_r;
    row_a        = row_wrap_pre ? '0 : row_pre[11:0];
    lane_a       = row_wrap_pre ? bnd_pkg::LANE0 : (col_wrap_pre ? inc3(lane_r) : lane_r);

    col_last = (({1'b0, col_a} + 13'd1) == w_r);
    row_last = (({1'b0, row_a} + 13'd1) == h_r);
    even_row = !row_a[0] && (row_a != '0);
    odd_last = row_a[0] && row_last;
    inner_j1 = (order_r == bnd_pkg::ORDER_GBRG) || (order_r == bnd_pkg::ORDER_GRBG);
    col_step = col_last || (!col_a[0] && (col_a != '0));
    trig     = even_row ? (inner_j1 ? col_a[0] : col_step) : (odd_last && col_step);

    quad_j = col_a[0] ? (col_a - 12'd1) : (col_a - 12'd2);
    quad_i = even_row ? (row_a - 12'd2) : (row_a - 12'd1);

    sel.lt    = even_row ? inc3(lane_a) : inc3(inc3(lane_a));
    sel.lm    = even_row ? inc3(inc3(lane_a)) : lane_a;
    sel.lb    = lane_a;
    sel.rin   = even_row;
    sel.cin   = (({1'b0, quad_j} + 13'd2) < w_r);
    sel.order = order_r;
    sel.row   = quad_i;
    sel.col   = quad_j;

    // Advance the raster position
    col_nxt  = col_last ? '0 : (col_a + 12'd1);
    row_nxt  = row_a;
    lane_nxt = lane_a;
    if (col_last) begin
      row_nxt  = row_last ? '0 : (row_a + 12'd1);
      lane_nxt = row_last ? bnd_pkg::LANE0 : inc3(lane_a);
    end

    // Read this column and the next one
    rd_addr = AW'(col_a);
    if ((32'(col_a) + 32'd1) < 32'(MAX_WIDTH)) begin
      look_addr = AW'({1'b0, col_a} + 13'd1);
    end else begin
      look_addr = AW'(col_a);
    end
  end

  // Hold items while the result buffer could overflow
  assign occupancy = {1'b0, qstat.busy} + {1'b0, qstat.pend} + {1'b0, s1_valid_r && s1_trig_r};
  assign in_ready  = rst_n && (occupancy < 2'd2);
  assign in_fire   = in_valid && in_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      lane_r     <= bnd_pkg::LANE0;
      s1_valid_r <= 1'b0;
      s1_trig_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s1_trig_r  <= in_fire && trig;
      if (in_fire) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        lane_r <= lane_nxt;
      end
    end
  end

  // Carry the item into the second stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_raw_value;
      s1_lane_r <= lane_a;
      s1_addr_r <= rd_addr;
      s1_odd_r  <= col_a[0];
      s1_sel_r  <= sel;
    end
  end

  // Line store: two reads on accept, write back the merged column from the second stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_cur_r  <= mem[rd_addr];
      rd_look_r <= mem[look_addr];
    end
    if (s1_valid_r) begin
      mem[s1_addr_r] <= merged;
    end
  end

  // Drop the new sample into its lane
  always_comb begin
    case (s1_lane_r)
      bnd_pkg::LANE0: merged = {rd_cur_r[23:8], s1_pix_r};
      bnd_pkg::LANE1: merged = {rd_cur_r[23:16], s1_pix_r, rd_cur_r[7:0]};
      default:        merged = {s1_pix_r, rd_cur_r[15:0]};
    endcase
  end

  // Shift the two previous columns of this row
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win1_r <= merged;
      win2_r <= win1_r;
    end
  end

  // Odd column: quad spans col-1..col+1; even column: col-2..col
  assign c0 = s1_odd_r ? win1_r : win2_r;
  assign c1 = s1_odd_r ? merged : win1_r;
  assign c2 = s1_odd_r ? rd_look_r : merged;

  bnd_quad_sel u_quad_sel (
    .c0   (c0),
    .c1   (c1),
    .c2   (c2),
    .sel  (s1_sel_r),
    .quad (quad)
  );

  assign push = s1_valid_r && s1_trig_r;

  bnd_out_queue u_out_queue (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .quad_in          (quad),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_col    (out_pixel_col),
    .out_last_of_quad (out_last_of_quad),
    .stat             (qstat)
  );

`include "bayer_nearest_demosaic_assert.svh"

  // A new quad must find a free slot in the result buffer
  `BND_ASSERT_SAME(a_push_slot, push && qstat.busy && !(out_valid && out_ready && out_last_of_quad), !qstat.pend, "quad pushed into a full result buffer")

  // The column counter stays inside the frame after each item
  `BND_ASSERT_NEXT(a_col_range, in_fire && !cfg_we, {1'b0, col_r} < w_r, "column counter beyond frame width")

  // The fourth pixel of a quad lies on an odd row and an odd column
  `BND_ASSERT_SAME(a_last_pos, out_valid && out_last_of_quad, out_pixel_row[0] && out_pixel_col[0], "last pixel of quad misplaced")

endmodule

@@ src/bnd_quad_sel.sv @@
module bnd_quad_sel (
  input  logic [23:0]    c0,
  input  logic [23:0]    c1,
  input  logic [23:0]    c2,
  input  bnd_pkg::sel_t  sel,
  output bnd_pkg::quad_t quad
);

  logic [7:0] t0, t1, t2, m0, m1, m2, b0, b1, b2;
  logic [7:0] s_a, s_b, s_c, s_d;
  logic [7:0] n_a, n_b, n_c, n_d;

  function automatic logic [7:0] lane_byte(input logic [23:0] w, input bnd_pkg::lane_t l);
    logic [7:0] v;
    case (l)
      bnd_pkg::LANE0: v = w[7:0];
      bnd_pkg::LANE1: v = w[15:8];
      default:        v = w[23:16];
    endcase
    return v;
  endfunction

  // Pick the nine samples of the 3x3 window
  always_comb begin
    t0 = lane_byte(c0, sel.lt);
    t1 = lane_byte(c1, sel.lt);
    t2 = lane_byte(c2, sel.lt);
    m0 = lane_byte(c0, sel.lm);
    m1 = lane_byte(c1, sel.lm);
    m2 = lane_byte(c2, sel.lm);
    b0 = lane_byte(c0, sel.lb);
    b1 = lane_byte(c1, sel.lb);
    b2 = lane_byte(c2, sel.lb);
  end

  // Own samples are t0 t1 m0 m1; fall back to them at the frame edge
  always_comb begin
    s_a = t0;
    s_b = t1;
    s_c = m0;
    s_d = m1;
    n_a = '0;
    n_b = '0;
    n_c = '0;
    n_d = '0;
    quad.row = sel.row;
    quad.col = sel.col;
    case (sel.order)
      bnd_pkg::ORDER_GBRG: begin
        // gb b / r gr
        n_a = sel.cin ? t2 : s_a;
        n_b = sel.cin ? m2 : s_c;
        n_c = sel.rin ? b1 : s_b;
        quad.blue  = {n_c, n_c, s_b, s_b};
        quad.green = {s_d, s_d, n_a, s_a};
        quad.red   = {n_b, s_c, n_b, s_c};
      end
      bnd_pkg::ORDER_BGGR: begin
        // b gb / gr r
        n_a = sel.cin ? t2 : s_a;
        n_b = sel.rin ? b0 : s_a;
        n_c = (sel.rin && sel.cin) ? b2 : s_a;
        n_d = sel.cin ? m2 : s_c;
        quad.blue  = {n_c, n_b, n_a, s_a};
        quad.green = {n_d, s_c, s_b, s_b};
        quad.red   = {s_d, s_d, s_d, s_d};
      end
      bnd_pkg::ORDER_GRBG: begin
        // gr r / b gb
        n_a = sel.cin ? m2 : s_c;
        n_b = sel.cin ? t2 : s_a;
        n_c = sel.rin ? b1 : s_b;
        quad.blue  = {n_a, s_c, n_a, s_c};
        quad.green = {s_d, s_d, n_b, s_a};
        quad.red   = {n_c, n_c, s_b, s_b};
      end
      default: begin
        // r gr / gb b
        n_a = sel.cin ? t2 : s_a;
        n_b = sel.rin ? b0 : s_a;
        n_c = sel.cin ? m2 : s_c;
        n_d = (sel.rin && sel.cin) ? b2 : s_a;
        quad.blue  = {s_d, s_d, s_d, s_d};
        quad.green = {n_c, s_c, s_b, s_b};
        quad.red   = {n_d, n_b, n_a, s_a};
      end
    endcase
  end

endmodule

@@ src/bnd_out_queue.sv @@
module bnd_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bnd_pkg::quad_t  quad_in,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_green,
  output logic [7:0]      out_red,
  output logic [11:0]     out_pixel_row,
  output logic [11:0]     out_pixel_col,
  output logic            out_last_of_quad,
  output bnd_pkg::qstat_t stat
);

  localparam logic [1:0] K_LAST = 2'd3;

  bnd_pkg::quad_t ser_q_r, ser_q_nxt;
  bnd_pkg::quad_t pend_q_r, pend_q_nxt;
  logic           ser_v_r, ser_v_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [1:0]     k_r, k_nxt;
  logic           out_fire;
  logic           ser_free;

  assign out_fire = ser_v_r && out_ready;
  assign ser_free = !ser_v_r || (out_fire && (k_r == K_LAST));

  // Refill the serialiser from the pending slot first, then from the new quad
  always_comb begin
    ser_q_nxt  = ser_q_r;
    ser_v_nxt  = ser_v_r;
    pend_q_nxt = pend_q_r;
    pend_v_nxt = pend_v_r;
    k_nxt      = k_r;
    if (ser_free) begin
      k_nxt = '0;
      if (pend_v_r) begin
        ser_q_nxt  = pend_q_r;
        ser_v_nxt  = 1'b1;
        pend_v_nxt = push;
        pend_q_nxt = quad_in;
      end else if (push) begin
        ser_q_nxt = quad_in;
        ser_v_nxt = 1'b1;
      end else begin
        ser_v_nxt = 1'b0;
      end
    end else begin
      if (out_fire) begin
        k_nxt = k_r + 2'd1;
      end
      if (push) begin
        pend_q_nxt = quad_in;
        pend_v_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      k_r      <= '0;
    end else begin
      ser_v_r  <= ser_v_nxt;
      pend_v_r <= pend_v_nxt;
      k_r      <= k_nxt;
    end
  end

  // Quad payload
  always_ff @(posedge clk) begin
    ser_q_r  <= ser_q_nxt;
    pend_q_r <= pend_q_nxt;
  end

  // Present pixel k of the held quad
  assign out_valid        = ser_v_r;
  assign out_blue         = ser_q_r.blue[k_r];
  assign out_green        = ser_q_r.green[k_r];
  assign out_red          = ser_q_r.red[k_r];
  assign out_pixel_row    = ser_q_r.row + {11'd0, k_r[1]};
  assign out_pixel_col    = ser_q_r.col + {11'd0, k_r[0]};
  assign out_last_of_quad = (k_r == K_LAST);

  assign stat.busy = ser_v_r;
  assign stat.pend = pend_v_r;

endmodule

@@ dv/bayer_nearest_demosaic_tb.sv @@
`timescale 1ns / 1ps

module bayer_nearest_demosaic_tb;
  import bnd_pkg::*;

  // One output pixel as it leaves the block
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
  } pix_t;

  // One 2x2 frame of the directed part, samples in raster order
  typedef struct packed {
    logic [1:0]      order;
    logic [3:0][7:0] raw;
    logic            typed;
    logic [3:0][7:0] blue;
    logic [3:0][7:0] green;
    logic [3:0][7:0] red;
  } quad_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_raw_value = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [11:0] out_pixel_row;
  logic [11:0] out_pixel_col;
  logic        out_last_of_quad;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [12:0] cfg_data = 13'd0;

  // Predictor state: registers, raster position and three stored rows
  logic [12:0] reg_width = WIDTH_RST;
  logic [12:0] reg_height = HEIGHT_RST;
  logic [1:0]  reg_order = ORDER_RGGB;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  logic [7:0]  line_mem [0:2][0:MAX_WIDTH_DEF-1];
  pix_t        quad_buf [4];

  pix_t        expected_pix [$];
  int          mismatch_count = 0;
  int          idle_level = 0;
  int          long_hold_reqs = 0;
  int          long_holds_served = 0;
  int          stall_left = 0;

  quad_case_t  quad_cases [6];

  bayer_nearest_demosaic dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_value     (in_raw_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_col    (out_pixel_col),
    .out_last_of_quad (out_last_of_quad),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Width in force: even, clamped to the store depth and to 4096
  function automatic int unsigned active_width();
    int unsigned cap;
    int unsigned w;
    cap = MAX_WIDTH_DEF & ~1;
    if (cap > 4096) cap = 4096;
    w = reg_width & 13'h1FFE;
    if (w > cap) w = cap;
    if (w < 2) w = 2;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = reg_height & 13'h1FFE;
    if (h > 4096) h = 4096;
    if (h < 2) h = 2;
    return h;
  endfunction

  function automatic logic [7:0] stored(int unsigned r, int unsigned c);
    return line_mem[r % 3][c];
  endfunction

  // Work out the four pixels of quad (i, j); edge neighbours fall back to own samples
  function automatic void build_quad(int unsigned i, int unsigned j,
                                     int unsigned w, int unsigned h);
    logic [7:0] q00, q01, q10, q11;
    logic [7:0] b [4];
    logic [7:0] g [4];
    logic [7:0] rd [4];
    logic [7:0] n0, n1, n2, n3;
    bit         rin, cin;
    q00 = stored(i, j);
    q01 = stored(i, j + 1);
    q10 = stored(i + 1, j);
    q11 = stored(i + 1, j + 1);
    rin = (i + 2) < h;
    cin = (j + 2) < w;
    case (reg_order)
      ORDER_GBRG: begin
        // gb = q00, b = q01, r = q10, gr = q11
        n0 = cin ? stored(i, j + 2) : q00;
        n1 = cin ? stored(i + 1, j + 2) : q10;
        n2 = rin ? stored(i + 2, j + 1) : q01;
        b  = '{q01, q01, n2, n2};
        g  = '{q00, n0, q11, q11};
        rd = '{q10, n1, q10, n1};
      end
      ORDER_BGGR: begin
        // b = q00, gb = q01, gr = q10, r = q11
        n0 = cin ? stored(i, j + 2) : q00;
        n1 = rin ? stored(i + 2, j) : q00;
        n2 = (rin && cin) ? stored(i + 2, j + 2) : q00;
        n3 = cin ? stored(i + 1, j + 2) : q10;
        b  = '{q00, n0, n1, n2};
        g  = '{q01, q01, q10, n3};
        rd = '{q11, q11, q11, q11};
      end
      ORDER_GRBG: begin
        // gr = q00, r = q01, b = q10, gb = q11
        n0 = cin ? stored(i + 1, j + 2) : q10;
        n1 = cin ? stored(i, j + 2) : q00;
        n2 = rin ? stored(i + 2, j + 1) : q01;
        b  = '{q10, n0, q10, n0};
        g  = '{q00, n1, q11, q11};
        rd = '{q01, q01, n2, n2};
      end
      default: begin
        // r = q00, gr = q01, gb = q10, b = q11
        n0 = cin ? stored(i, j + 2) : q00;
        n1 = rin ? stored(i + 2, j) : q00;
        n2 = cin ? stored(i + 1, j + 2) : q10;
        n3 = (rin && cin) ? stored(i + 2, j + 2) : q00;
        b  = '{q11, q11, q11, q11};
        g  = '{q01, q01, q10, n2};
        rd = '{q00, n0, n1, n3};
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      quad_buf[k].blue  = b[k];
      quad_buf[k].green = g[k];
      quad_buf[k].red   = rd[k];
      quad_buf[k].row   = 12'(i + (k >> 1));
      quad_buf[k].col   = 12'(j + (k & 1));
      quad_buf[k].last  = (k == 3);
    end
  endfunction

  // Store one sample and return how many pixels it releases (0 or 4)
  function automatic int model_pixel(logic [7:0] v);
    int unsigned w, h, r, c;
    int          n;
    w = active_width();
    h = active_height();
    n = 0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    line_mem[r % 3][c] = v;
    if (r % 2 == 0 && r >= 2) begin
      if (reg_order[0] == 1'b0) begin
        // GBRG and GRBG emit inner quad rows one column early
        if (c % 2 == 1) begin
          build_quad(r - 2, c - 1, w, h);
          n = 4;
        end
      end else if (c == w - 1) begin
        build_quad(r - 2, w - 2, w, h);
        n = 4;
      end else if (c % 2 == 0 && c >= 2) begin
        build_quad(r - 2, c - 2, w, h);
        n = 4;
      end
    end else if (r % 2 == 1 && r == h - 1) begin
      // Bottom quad row: no row below to wait for
      if (c == w - 1) begin
        build_quad(r - 1, w - 2, w, h);
        n = 4;
      end else if (c % 2 == 0 && c >= 2) begin
        build_quad(r - 1, c - 2, w, h);
        n = 4;
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return n;
  endfunction

  // Offer one sample, hold it until taken, then advance the predictor
  task automatic send_pixel(input logic [7:0] v, output int n);
    int odds;
    odds = (idle_level == 2) ? 3 : 15;
    if (idle_level != 0 && $urandom_range(0, odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = model_pixel(v);
  endtask

  task automatic push_quad(input int n);
    for (int k = 0; k < n; k++) expected_pix.push_back(quad_buf[k]);
  endtask

  task automatic feed(input logic [7:0] v);
    int n;
    send_pixel(v, n);
    push_quad(n);
  endtask

  function automatic logic [7:0] pick_sample();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Drop valid, wait for every pending pixel, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all three registers back to back
  task automatic set_frame(input logic [12:0] w, input logic [12:0] h,
                           input logic [1:0] ord);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    reg_width = w;
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    reg_height = h;
    cfg_index <= CFG_BAYER_ORDER;
    cfg_data  <= {11'd0, ord};
    @(posedge clk);
    reg_order = ord;
    cfg_we <= 1'b0;
  endtask

  task automatic run_frames(input int frames);
    for (int f = 0; f < frames; f++)
      for (int k = 0; k < active_width() * active_height(); k++) feed(pick_sample());
  endtask

  // Receiver: random stalls, plus a long hold whenever one is requested
  always @(posedge clk) begin
    if (long_hold_reqs != long_holds_served) begin
      long_holds_served++;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_level != 0 &&
                 $urandom_range(0, (idle_level == 2) ? 3 : 15) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin : check_pixels
    pix_t got;
    pix_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_blue, out_green, out_red, out_pixel_row, out_pixel_col,
              out_last_of_quad};
      if (expected_pix.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected pixel: b=%0d g=%0d r=%0d row=%0d col=%0d last=%0b",
                   got.blue, got.green, got.red, got.row, got.col, got.last);
      end else begin
        want = expected_pix.pop_front();
        if (got.blue !== want.blue || got.green !== want.green ||
            got.red !== want.red || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("pixel mismatch: exp b=%0d g=%0d r=%0d row=%0d col=%0d last=%0b, got b=%0d g=%0d r=%0d row=%0d col=%0d last=%0b",
                     want.blue, want.green, want.red, want.row, want.col, want.last,
                     got.blue, got.green, got.red, got.row, got.col, got.last);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int n;
    int random_items;
    logic [12:0] w_set, h_set;
    quad_case_t qc;

    // Typed rows are all-zero, all-ones and a plain RGGB quad; the rest use the predictor
    quad_cases = '{
      '{ORDER_RGGB, 32'h00000000, 1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
      '{ORDER_RGGB, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
      '{ORDER_RGGB, 32'h78563412, 1'b1, 32'h78787878, 32'h56563434, 32'h12121212},
      '{ORDER_GBRG, 32'h3CC35AA5, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ORDER_BGGR, 32'h0FF01EE1, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ORDER_GRBG, 32'h81187EE7, 1'b0, 32'h0, 32'h0, 32'h0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: two full rows at 640 wide, then part of the third;
    // the receiver holds off long enough to back the input up
    idle_level = 1;
    for (int k = 0; k < 640 * 2 + 40; k++) begin
      if (k == 640 * 2) long_hold_reqs++;
      feed(pick_sample());
    end
    wait_drained();

    // Directed 2x2 frames; the counters wrap into a fresh frame
    for (int t = 0; t < 6; t++) begin
      qc = quad_cases[t];
      idle_level = t % 3;
      set_frame(13'd2, 13'd2, qc.order);
      for (int k = 0; k < 4; k++) begin
        send_pixel(qc.raw[k], n);
        if (n != 0 && qc.typed) begin
          for (int p = 0; p < 4; p++) begin
            quad_buf[p].blue  = qc.blue[p];
            quad_buf[p].green = qc.green[p];
            quad_buf[p].red   = qc.red[p];
          end
        end
        push_quad(n);
      end
      wait_drained();
    end

    // Widest frame (an oversized write clamps to 4096), then tallest
    idle_level = 1;
    set_frame(13'h1FFF, 13'd2, ORDER_GBRG);
    run_frames(1);
    wait_drained();
    idle_level = 0;
    set_frame(13'd0, 13'd4097, ORDER_GRBG);
    run_frames(1);
    wait_drained();

    // Random small frames; odd and zero sizes now and then
    random_items = 0;
    while (random_items < 460) begin
      idle_level = (random_items >= 400) ? 0 : $urandom_range(0, 2);
      if ($urandom_range(0, 4) == 0) w_set = 13'($urandom_range(0, 17));
      else w_set = 13'(2 * $urandom_range(1, 8));
      if ($urandom_range(0, 4) == 0) h_set = 13'($urandom_range(0, 11));
      else h_set = 13'(2 * $urandom_range(1, 5));
      set_frame(w_set, h_set, 2'($urandom_range(0, 3)));
      n = $urandom_range(1, 2);
      run_frames(n);
      random_items += n * active_width() * active_height();
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_pix.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
